// ===== src/scbs_pkg.sv =====
// Package for the sorted coordinate table search block.
// Holds the shared constants, word types and the search controller states.
// No dependencies.
package scbs_pkg;

    // Default table size and fixed field widths
    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 16;
    localparam int IDX_W       = 10;
    localparam int COUNT_W     = 11;

    // Action codes carried on s_tuser
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // One coordinate key, x most significant in the ordering
    typedef struct packed {
        logic signed [KEY_W-1:0] x;
        logic signed [KEY_W-1:0] y;
        logic signed [KEY_W-1:0] z;
    } key_t;

    // One queued word: action and key (table address travels alongside)
    typedef struct packed {
        logic action;
        key_t key;
    } item_t;

    // Search controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_RESP
    } state_t;

endpackage

// ===== src/sorted_coord3_binary_search.sv =====
// Sorted (x,y,z) key table with lexicographic binary search.
// Load word: written by the search engine from its idle state. Lookup: a read state
// (registered table read) and a compare state per probe, up to log2(DEPTH)+1 probes,
// then the result register; one lookup is searched at a time while the queue takes words.
// Reset clears control state and entry_count; table contents stay undefined.
// Depends on scbs_pkg, scbs_front, scbs_back, scbs_ram.
module sorted_coord3_binary_search #(
    parameter int TABLE_DEPTH = scbs_pkg::TABLE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [scbs_pkg::COUNT_W-1:0] cfg_wdata,  // entry_count
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,    // entry_index, key_x, key_y, key_z
    input  logic [0:0]                   s_tuser,    // action
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,    // match_index
    output logic [0:0]                   m_tuser     // found
);

    logic                           q_valid;
    logic                           q_pop;
    scbs_pkg::item_t                q_item;
    logic [$clog2(TABLE_DEPTH)-1:0] q_addr;
    logic                           m_found;
    logic [scbs_pkg::IDX_W-1:0]     m_index;

    // Front end and queue
    scbs_front #(
        .DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .q_addr   (q_addr)
    );

    // Search engine
    scbs_back #(
        .DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .q_addr    (q_addr),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_found   (m_found),
        .m_index   (m_index)
    );

    assign m_tdata = {6'd0, m_index};
    assign m_tuser = m_found;

endmodule

// ===== src/scbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
// Used for the key table.
module scbs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/scbs_front.sv =====
// Front end: takes input words, reduces the entry index to a table address
// and holds them in a two-entry queue for the search engine.
// Depends on scbs_pkg.
module scbs_front #(
    parameter int DEPTH = scbs_pkg::TABLE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [63:0]              s_tdata,
    input  logic [0:0]               s_tuser,
    output logic                     q_valid,
    input  logic                     q_pop,
    output scbs_pkg::item_t          q_item,
    output logic [$clog2(DEPTH)-1:0] q_addr
);

    localparam int AW = $clog2(DEPTH);

    scbs_pkg::item_t           item_reg [2];
    logic [AW-1:0]             addr_reg [2];
    logic                      wr_ptr_reg, wr_ptr_next;
    logic                      rd_ptr_reg, rd_ptr_next;
    logic [1:0]                fill_reg, fill_next;
    logic                      push;
    logic [scbs_pkg::IDX_W-1:0] rem;
    scbs_pkg::item_t           in_item;

    // Unpack the incoming word
    always_comb
    begin
        in_item.action = s_tuser[0];
        in_item.key.x  = s_tdata[25:10];
        in_item.key.y  = s_tdata[41:26];
        in_item.key.z  = s_tdata[57:42];
    end

    // Entry index modulo table depth: restoring subtraction of depth multiples
    always_comb
    begin
        rem = s_tdata[9:0];
        for (int k = scbs_pkg::IDX_W - 1; k >= 0; k--)
        begin
            if ((longint'(DEPTH) << k) < (longint'(1) << scbs_pkg::IDX_W))
            begin
                if ({22'd0, rem} >= 32'(DEPTH << k))
                begin
                    rem = rem - scbs_pkg::IDX_W'(DEPTH << k);
                end
            end
        end
    end

    // Queue pointers and fill level
    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = item_reg[rd_ptr_reg];
    assign q_addr   = addr_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg[wr_ptr_reg] <= in_item;
            addr_reg[wr_ptr_reg] <= AW'(rem);
        end
    end

endmodule

// ===== src/scbs_back.sv =====
// Back end: writes table entries and runs the binary search, a read state and a compare state a probe.
// Holds the entry count register and the result register.
// Depends on scbs_pkg and scbs_ram.
module scbs_back #(
    parameter int DEPTH = scbs_pkg::TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [scbs_pkg::COUNT_W-1:0]  cfg_wdata,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  scbs_pkg::item_t               q_item,
    input  logic [$clog2(DEPTH)-1:0]      q_addr,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          m_found,
    output logic [scbs_pkg::IDX_W-1:0]    m_index
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    scbs_pkg::state_t            state_reg, state_next;
    logic [scbs_pkg::COUNT_W-1:0] count_reg;
    logic [CW-1:0]               lo_reg, lo_next;
    logic [CW-1:0]               hi_reg, hi_next;
    logic [AW-1:0]               mid_reg, mid_next;
    scbs_pkg::key_t              key_reg, key_next;
    logic                        found_reg, found_next;
    logic [AW-1:0]               where_reg, where_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        m_found_reg, m_found_next;
    logic [scbs_pkg::IDX_W-1:0]  m_index_reg, m_index_next;

    logic [CW-1:0]               count_sat;
    logic [CW-1:0]               mid_c;
    logic [CW-1:0]               mid_ext;
    logic [CW-1:0]               lo_upd, hi_upd;
    logic [$bits(scbs_pkg::key_t)-1:0] ram_rdata;
    scbs_pkg::key_t              entry;
    logic                        ram_we, ram_re;
    logic                        is_eq, is_less;
    logic                        out_free;
    logic                        start_lookup;

    // Signed lexicographic less-than
    function automatic logic lex_less(input scbs_pkg::key_t a, input scbs_pkg::key_t b);
        logic res;
        begin
            if (a.x != b.x)
                res = (a.x < b.x);
            else if (a.y != b.y)
                res = (a.y < b.y);
            else
                res = (a.z < b.z);
            return res;
        end
    endfunction

    // Key table
    scbs_ram #(
        .WIDTH ($bits(scbs_pkg::key_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_addr),
        .wdata (q_item.key),
        .re    (ram_re),
        .raddr (mid_c[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Search window arithmetic
    always_comb
    begin
        if (32'(count_reg) > 32'(DEPTH))
            count_sat = CW'(DEPTH);
        else
            count_sat = CW'(count_reg);
        mid_c   = lo_reg + ((hi_reg - lo_reg - CW'(1)) >> 1);
        mid_ext = CW'(mid_reg);
        entry   = scbs_pkg::key_t'(ram_rdata);
        is_eq   = (entry == key_reg);
        is_less = lex_less(entry, key_reg);
        lo_upd  = is_less ? mid_ext + CW'(1) : lo_reg;
        hi_upd  = is_less ? hi_reg : mid_ext;
        out_free     = !m_tvalid_reg || m_tready;
        start_lookup = q_valid && (q_item.action == scbs_pkg::ACT_LOOKUP);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scbs_pkg::ST_IDLE:
            begin
                if (start_lookup)
                    state_next = (count_sat == '0) ? scbs_pkg::ST_RESP : scbs_pkg::ST_READ;
            end
            scbs_pkg::ST_READ:
            begin
                state_next = scbs_pkg::ST_CMP;
            end
            scbs_pkg::ST_CMP:
            begin
                if (is_eq || !(lo_upd < hi_upd))
                    state_next = scbs_pkg::ST_RESP;
                else
                    state_next = scbs_pkg::ST_READ;
            end
            scbs_pkg::ST_RESP:
            begin
                if (out_free)
                    state_next = scbs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = scbs_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs
    always_comb
    begin
        q_pop  = 1'b0;
        ram_we = 1'b0;
        ram_re = 1'b0;
        case (state_reg)
            scbs_pkg::ST_IDLE:
            begin
                q_pop  = q_valid;
                ram_we = q_valid && (q_item.action == scbs_pkg::ACT_LOAD);
            end
            scbs_pkg::ST_READ:
            begin
                ram_re = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        key_next      = key_reg;
        found_next    = found_reg;
        where_next    = where_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_found_next  = m_found_reg;
        m_index_next  = m_index_reg;
        case (state_reg)
            scbs_pkg::ST_IDLE:
            begin
                if (start_lookup)
                begin
                    key_next   = q_item.key;
                    lo_next    = '0;
                    hi_next    = count_sat;
                    found_next = 1'b0;
                    where_next = '0;
                end
            end
            scbs_pkg::ST_READ:
            begin
                mid_next = mid_c[AW-1:0];
            end
            scbs_pkg::ST_CMP:
            begin
                if (is_eq)
                begin
                    found_next = 1'b1;
                    where_next = mid_reg;
                end
                else
                begin
                    lo_next = lo_upd;
                    hi_next = hi_upd;
                end
            end
            scbs_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = found_reg;
                    m_index_next  = scbs_pkg::IDX_W'(where_reg);
                end
            end
            default:
            begin
                mid_next = mid_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= scbs_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
                count_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        key_reg     <= key_next;
        found_reg   <= found_next;
        where_reg   <= where_next;
        m_found_reg <= m_found_next;
        m_index_reg <= m_index_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_found  = m_found_reg;
    assign m_index  = m_index_reg;

endmodule

// ===== src/scbs_checker.sv =====
// Port-level checks for the search block, bound to the top level.
// Depends on sorted_coord3_binary_search.
module scbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic [3:0] pending_reg, pending_next;
    logic       lookup_in, result_out;

    // Lookups accepted but not yet answered
    assign lookup_in  = s_tvalid && s_tready && s_tuser[0];
    assign result_out = m_tvalid && m_tready;
    assign pending_next = pending_reg + 4'(lookup_in) - 4'(result_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // A result word only exists for an outstanding lookup
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pending_reg != 4'd0))
        else $error("result word without outstanding lookup");

    // A miss reports index zero, every result keeps the index in range
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0))
        else $error("miss with nonzero index");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:10] == 6'd0))
        else $error("match index exceeds field width");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind sorted_coord3_binary_search scbs_checker u_scbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_sorted_coord3_binary_search.sv =====
// Testbench for the sorted (x,y,z) key table with lexicographic binary search.
// Loads mostly sorted tables, sets entry_count and checks every result word against a
// local search model or a fixed expected result. Depends on scbs_pkg and sorted_coord3_binary_search.
`timescale 1ns / 100ps

module tb_sorted_coord3_binary_search;

    // Offset-binary flip: makes a packed key compare as unsigned in lex order
    localparam logic [47:0] SIGN_FLIP = 48'h8000_8000_8000;
    localparam int          SETTLE    = 64;

    typedef struct {
        logic       hit;
        logic [9:0] where;
    } search_result_t;

    typedef struct {
        logic        do_cfg;
        int          cfg_val;
        logic        action;
        logic [9:0]  idx;
        int          x;
        int          y;
        int          z;
        logic        typed;
        logic        hit;
        logic [9:0]  where;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [scbs_pkg::COUNT_W-1:0]  cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [63:0]                   s_tdata = '0;
    logic [0:0]                    s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [15:0]                   m_tdata;
    logic [0:0]                    m_tuser;

    // Local copy of the block state
    scbs_pkg::key_t      key_store [scbs_pkg::TABLE_DEPTH];
    int                  search_count = 0;
    search_result_t      pending_results [$];
    int                  spine_at [$];

    int                  errors = 0;
    int                  words_sent = 0;
    int                  s_idle_pct = 0;
    int                  r_idle_pct = 0;
    int                  s_calm = 0;
    int                  r_calm = 0;

    sorted_coord3_binary_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // entry_index, key_x, key_y, key_z
        .s_tuser   (s_tuser),    // action
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // match_index
        .m_tuser   (m_tuser)     // found
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_sorted_coord3_binary_search failed");
        $finish;
    end

    // Random gap decision, with occasional calm stretches of no gaps at all
    function automatic bit roll_gap(input int pct, inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 1'b0;
        end
        if ($urandom_range(0, 49) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic scbs_pkg::key_t make_key(input int x, input int y, input int z);
        scbs_pkg::key_t k;
        k.x = 16'(x);
        k.y = 16'(y);
        k.z = 16'(z);
        return k;
    endfunction

    function automatic logic [47:0] key_rank(input scbs_pkg::key_t k);
        return 48'(k) ^ SIGN_FLIP;
    endfunction

    // Binary search over the local table, same probe order as the block
    function automatic search_result_t search_keys(input scbs_pkg::key_t k);
        search_result_t r;
        int lo;
        int hi;
        int mid;
        r.hit   = 1'b0;
        r.where = '0;
        lo = 0;
        hi = ((search_count > scbs_pkg::TABLE_DEPTH) ? scbs_pkg::TABLE_DEPTH
                                                     : search_count) - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (key_store[mid] == k)
            begin
                r.hit   = 1'b1;
                r.where = 10'(mid);
                break;
            end
            if (key_rank(key_store[mid]) < key_rank(k))
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return r;
    endfunction

    // Present one word and hold it until accepted; update the model on accept
    task automatic send_word(input logic act, input logic [9:0] idx,
                             input scbs_pkg::key_t k,
                             input logic typed, input search_result_t fixed);
        while (roll_gap(s_idle_pct, s_calm))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, k.z, k.y, k.x, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (act == scbs_pkg::ACT_LOAD)
            key_store[idx] = k;
        else if (typed)
            pending_results = {pending_results, fixed};
        else
            pending_results = {pending_results, search_keys(k)};
    endtask

    task automatic send_plain(input logic act, input logic [9:0] idx,
                              input scbs_pkg::key_t k);
        search_result_t none;
        none.hit   = 1'b0;
        none.where = '0;
        send_word(act, idx, k, 1'b0, none);
    endtask

    // Stop sending, let every result arrive and the load queue empty out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_count(input int v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= scbs_pkg::COUNT_W'(v);
        search_count = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic scbs_pkg::key_t random_key();
        return scbs_pkg::key_t'(48'({$urandom(), $urandom()}));
    endfunction

    // Fill entries 0..n-1 with sorted keys; sometimes unsorted, some stray loads
    task automatic load_table(input int n);
        logic [47:0]    ranks [$];
        logic [47:0]    t;
        scbs_pkg::key_t k;
        int             spread;
        int             a;
        int             b;
        bit             down;
        spread = $urandom_range(0, 2);
        down   = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
        begin
            k = random_key();
            if (spread != 0)
            begin
                k.x = 16'(int'($urandom_range(0, 6)) - 3);
                k.y = 16'(int'($urandom_range(0, 6)) - 3);
            end
            if (spread == 2)
                k.z = 16'(int'($urandom_range(0, 4)) - 2);
            ranks = {ranks, key_rank(k)};
        end
        ranks.sort();
        if (n > 1 && $urandom_range(0, 6) == 0)
        begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            t = ranks[a];
            ranks[a] = ranks[b];
            ranks[b] = t;
        end
        for (int i = 0; i < n; i++)
        begin
            a = down ? n - 1 - i : i;
            send_plain(scbs_pkg::ACT_LOAD, 10'(a), scbs_pkg::key_t'(ranks[a] ^ SIGN_FLIP));
            if ($urandom_range(0, 19) == 0)
                send_plain(scbs_pkg::ACT_LOAD, 10'($urandom()), random_key());
        end
    endtask

    // Lookups: mostly keys present in the table, plus near misses and noise
    task automatic probe_table(input int n, input int m);
        scbs_pkg::key_t k;
        int             pick;
        for (int i = 0; i < m; i++)
        begin
            pick = $urandom_range(0, 99);
            k = key_store[$urandom_range(0, n - 1)];
            if (pick >= 55 && pick < 80)
                k.z = k.z + (($urandom_range(0, 1) != 0) ? 16'sd1 : -16'sd1);
            else if (pick >= 80 && pick < 95)
                k = random_key();
            else if (pick >= 95)
                k = ($urandom_range(0, 1) != 0) ? scbs_pkg::key_t'(48'h8000_8000_8000)
                                                : scbs_pkg::key_t'(48'h7FFF_7FFF_7FFF);
            send_plain(scbs_pkg::ACT_LOOKUP, 10'($urandom()), k);
            if ($urandom_range(0, 19) == 0)
                send_plain(scbs_pkg::ACT_LOAD, 10'($urandom()), random_key());
        end
    endtask

    task automatic random_set();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 300) : $urandom_range(1, 40);
        load_table(n);
        set_count(($urandom_range(0, 3) != 0) ? n : $urandom_range(0, n));
        probe_table(n, $urandom_range(10, 30));
    endtask

    // Entries a full-size search reaches when it always goes left or always
    // right; loaded with keys rising with the index
    task automatic load_spine();
        logic [47:0] ranks [$];
        int          lo;
        int          hi;
        int          mid;
        spine_at.delete();
        lo = 0;
        hi = scbs_pkg::TABLE_DEPTH - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            spine_at = {spine_at, mid};
            hi = mid - 1;
        end
        lo = 0;
        hi = scbs_pkg::TABLE_DEPTH - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (mid != spine_at[0])
                spine_at = {spine_at, mid};
            lo = mid + 1;
        end
        spine_at.sort();
        for (int i = 0; i < spine_at.size(); i++)
            ranks = {ranks, key_rank(random_key())};
        ranks.sort();
        for (int i = 0; i < spine_at.size(); i++)
            send_plain(scbs_pkg::ACT_LOAD, 10'(spine_at[i]),
                       scbs_pkg::key_t'(ranks[i] ^ SIGN_FLIP));
    endtask

    // Lookups that stay on the loaded spine: its keys and the extreme keys
    task automatic probe_spine(input int m);
        scbs_pkg::key_t k;
        for (int i = 0; i < m; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                k = ($urandom_range(0, 1) != 0) ? scbs_pkg::key_t'(48'h8000_8000_8000)
                                                : scbs_pkg::key_t'(48'h7FFF_7FFF_7FFF);
            else
                k = key_store[spine_at[$urandom_range(0, spine_at.size() - 1)]];
            send_plain(scbs_pkg::ACT_LOOKUP, 10'($urandom()), k);
        end
    endtask

    // Result checker and receiver back-pressure
    always @(posedge clk)
    begin
        search_result_t want;
        m_tready <= !roll_gap(r_idle_pct, r_calm);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with none expected (found %0d index %0d)",
                         $time, m_tuser[0], m_tdata[9:0]);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.hit)
                begin
                    $display("%0t: found expected %0d got %0d", $time, want.hit, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[9:0] !== want.where)
                begin
                    $display("%0t: match_index expected %0d got %0d",
                             $time, want.where, m_tdata[9:0]);
                    errors++;
                end
            end
        end
    end

    // Directed rows: count zero, extreme keys, sign handling, unsorted table
    stim_row_t rows [22] = '{
        '{1, 0, scbs_pkg::ACT_LOOKUP, 10'd0,    0,      0,      0,      1, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOOKUP, 10'd1023, 32767,  32767,  32767,  1, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOAD,   10'd0,   -32768, -32768, -32768,  0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOAD,   10'd1,   -32768, -32768,  32767,  0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOAD,   10'd2,   -32768,  0,      0,      0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOAD,   10'd3,   -1,      5,     -7,      0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOAD,   10'd4,    0,      0,      0,      0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOAD,   10'd5,    0,      0,      1,      0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOAD,   10'd6,    1,     -1,     -1,      0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOAD,   10'd7,    32767,  32767,  32767,  0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOAD,   10'd1023,-1,     -1,     -1,      0, 0, 10'd0},
        '{1, 8, scbs_pkg::ACT_LOOKUP, 10'd0,   -32768, -32768, -32768,  0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOOKUP, 10'd0,    32767,  32767,  32767,  0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOOKUP, 10'd0,    0,      0,      1,      0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOOKUP, 10'd0,    0,      0,      2,      0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOOKUP, 10'd0,   -1,      5,     -8,      0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOOKUP, 10'd0,   -32768,  0,      0,      0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOOKUP, 10'd0,    1,     -1,     -1,      0, 0, 10'd0},
        '{1, 1, scbs_pkg::ACT_LOOKUP, 10'd0,   -32768, -32768, -32768,  0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOAD,   10'd2,    32767,  0,      0,      0, 0, 10'd0},
        '{1, 8, scbs_pkg::ACT_LOOKUP, 10'd0,    32767,  0,      0,      0, 0, 10'd0},
        '{0, 0, scbs_pkg::ACT_LOOKUP, 10'd0,   -32768,  0,      0,      0, 0, 10'd0}
    };

    // Main sequence
    initial
    begin
        search_result_t fixed;
        s_idle_pct = 30;
        r_idle_pct = 66;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].do_cfg)
                set_count(rows[i].cfg_val);
            fixed.hit   = rows[i].hit;
            fixed.where = rows[i].where;
            send_word(rows[i].action, rows[i].idx,
                      make_key(rows[i].x, rows[i].y, rows[i].z), rows[i].typed, fixed);
        end

        while (words_sent < 300)
            random_set();
        s_idle_pct = 66;
        r_idle_pct = 30;
        while (words_sent < 600)
            random_set();
        s_idle_pct = 0;
        r_idle_pct = 0;
        while (words_sent < 750)
            random_set();

        // Spine of a full-size table, then counts at, past and just below the table size
        load_spine();
        set_count(scbs_pkg::TABLE_DEPTH);
        probe_spine(20);
        set_count(2047);
        probe_spine(15);
        set_count($urandom_range(scbs_pkg::TABLE_DEPTH + 1, 2046));
        probe_spine(10);
        set_count(scbs_pkg::TABLE_DEPTH - 1);
        probe_spine(10);

        drain();
        if (errors == 0)
            $display("tb_sorted_coord3_binary_search passed");
        else
            $display("tb_sorted_coord3_binary_search failed");
        $finish;
    end

endmodule
